// ===== rtl/upd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent decoder package
// Shared types, character codes and the hex digit decode used by the front
// end, the run queue and the back end.
// ----------------------------------------------------------------------------
package upd_pkg;

	// Character codes.
	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChDig0    = 8'h30;
	localparam logic [7:0] ChDig9    = 8'h39;
	localparam logic [7:0] ChLowA    = 8'h61;
	localparam logic [7:0] ChLowF    = 8'h66;
	localparam logic [7:0] ChUpA     = 8'h41;
	localparam logic [7:0] ChUpF     = 8'h46;

	// Run queue geometry.
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	// Up to three decoded bytes produced by one input item.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            fin;
	} run_t;

	// Result of classifying one character as a hex digit.
	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	// Decodes a hex digit of either case; the value is zero when not a digit.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= ChDig0 && c <= ChDig9) begin
			h.valid = 1'b1;
			h.value = c[3:0];
		end else if ((c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF)) begin
			h.valid = 1'b1;
			h.value = 4'(c[2:0] + 3'd1) + 4'd8;
		end
		return h;
	endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
`timescale 1ns / 1ps
// An accepted item's run is written into the run queue and is shown once it reaches the head.
// Throughput: one item per cycle while the queue is not full and each item gives at most
// one byte; an item giving two or three bytes holds the result side for that many pops.
// The four-entry run queue between the classifier and the byte walker sets the slack.
// Reset (arst_n low, asynchronous) clears the escape state and empties the queue.
// ----------------------------------------------------------------------------
// URL percent decoder
// Decodes percent escapes and plus signs in a byte stream, queueing the runs
// of decoded bytes between a classifying front end and a serialising back end.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       stream_end
);

	run_t front_run, head_run;
	logic front_valid, accept, head_pop;

	assign accept = push && !full;

	// Classifier and escape state.
	upd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.accept     (accept),
		.run        (front_run),
		.run_valid  (front_valid)
	);

	// Runs waiting to be delivered.
	upd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && front_valid),
		.wr_run (front_run),
		.rd_en  (head_pop),
		.head   (head_run),
		.full   (full),
		.empty  (empty)
	);

	// Result serialiser.
	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_run),
		.head_empty (empty),
		.pop        (pop),
		.head_pop   (head_pop),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	// Runs without bytes are never queued.
	a_head_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> head_run.count != 2'd0)
		else $error("queued run holds no bytes");

	// The end of the stream is always the end of a run.
	a_stream_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && stream_end) |-> run_end)
		else $error("stream end without run end");

	// A run that is only partly delivered stays at the head.
	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !run_end) |=> !empty)
		else $error("run lost before its last byte");

endmodule

// ===== rtl/upd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent decoder front end
// Classifies each incoming item against the escape state and forms the run
// of decoded bytes that it causes.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	input  logic       accept,
	output run_t       run,
	output logic       run_valid
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	phase_t     phase_q, phase_nxt;
	logic [7:0] held_q, held_nxt;
	hex_t       hd, hh;
	logic [7:0] mapped;
	logic       is_pct;

	// Work out the decoded bytes and the next escape state for this item.
	always_comb begin
		hd        = hex_decode(in_byte);
		hh        = hex_decode(held_q);
		mapped    = (in_byte == ChPlus) ? ChSpace : in_byte;
		is_pct    = (in_byte == ChPercent);
		run       = '0;
		run.fin   = final_byte;
		phase_nxt = phase_q;
		held_nxt  = held_q;
		case (phase_q)
			PH_PCT: begin
				if (hd.valid) begin
					phase_nxt = PH_DIGIT;
					held_nxt  = in_byte;
				end else begin
					run.bytes[0] = ChPercent;
					run.count    = 2'd1;
					if (!is_pct) begin
						run.bytes[1] = mapped;
						run.count    = 2'd2;
						phase_nxt    = PH_IDLE;
					end
				end
			end
			PH_DIGIT: begin
				held_nxt = '0;
				if (hd.valid) begin
					run.bytes[0] = {hh.value, hd.value};
					run.count    = 2'd1;
					phase_nxt    = PH_IDLE;
				end else begin
					// The held digit is neither a plus nor a percent sign, so it
					// passes through unchanged.
					run.bytes[0] = ChPercent;
					run.bytes[1] = held_q;
					run.count    = 2'd2;
					if (is_pct) begin
						phase_nxt = PH_PCT;
					end else begin
						run.bytes[2] = mapped;
						run.count    = 2'd3;
						phase_nxt    = PH_IDLE;
					end
				end
			end
			default: begin
				if (is_pct) begin
					phase_nxt = PH_PCT;
					held_nxt  = '0;
				end else begin
					run.bytes[0] = mapped;
					run.count    = 2'd1;
					phase_nxt    = PH_IDLE;
				end
			end
		endcase

		// The end of the stream flushes any open escape literally.
		if (final_byte) begin
			if (phase_nxt == PH_PCT) begin
				if (run.count != 2'd3) begin
					run.bytes[run.count] = ChPercent;
					run.count            = run.count + 2'd1;
				end
			end else if (phase_nxt == PH_DIGIT) begin
				// A digit is only newly held when no byte has been produced.
				run.bytes[0] = ChPercent;
				run.bytes[1] = held_nxt;
				run.count    = 2'd2;
			end
			phase_nxt = PH_IDLE;
			held_nxt  = '0;
		end
		run_valid = (run.count != 2'd0);
	end

	// Escape state, updated on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

endmodule

// ===== rtl/upd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent decoder run queue
// A short first-in first-out queue of decoded runs between the front end and
// the back end.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  run_t wr_run,
	input  logic rd_en,
	output run_t head,
	output logic full,
	output logic empty
);

	run_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full  = (cnt_q == QCntW'(QDepth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_run;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/upd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent decoder back end
// Walks through the bytes of the oldest run, one result item per pop, and
// marks the end of each run and of the stream.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  run_t       head,
	input  logic       head_empty,
	input  logic       pop,
	output logic       head_pop,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       stream_end
);

	logic [1:0] idx_q;
	logic       take;

	// Select the current byte of the oldest run.
	always_comb begin
		take       = pop && !head_empty;
		out_byte   = head.bytes[idx_q];
		run_end    = (idx_q == head.count - 2'd1);
		stream_end = run_end && head.fin;
		head_pop   = take && run_end;
	end

	// Byte index within the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			if (run_end) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Drives encoded text into the decoder in bursts, pops decoded bytes on a
// stall pattern of its own and checks every decoded byte, with its run and
// stream end flags, against a predictor of the escape and plus handling.
// ----------------------------------------------------------------------------
module tb_top import upd_pkg::*; ();

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned HoldCycles = 60;
	localparam int unsigned RandomItems = 450;

	// Escape progress of the predictor.
	typedef enum logic [1:0] {
		PhIdle,
		PhPercent,
		PhDigit
	} esc_phase_t;

	// One decoded byte as it leaves the block.
	typedef struct {
		logic [7:0] out_byte;
		logic       run_end;
		logic       stream_end;
	} decoded_t;

	// One raw byte of encoded text with its end of stream flag.
	typedef struct {
		logic [7:0] b;
		logic       fin;
	} raw_item_t;

	// Predicts the decoded bytes of each accepted item and checks the results.
	class percent_board;
		esc_phase_t phase;
		logic [7:0] held_digit;
		logic [7:0] run_bytes[$];
		decoded_t   expected_bytes[$];
		int         errors;

		function new();
			phase = PhIdle;
			held_digit = 8'h00;
			errors = 0;
		endfunction

		// Value of a hex digit of either case, or -1 for any other character.
		static function int digit_value(logic [7:0] c);
			if (c >= ChDig0 && c <= ChDig9)
				return int'(c) - int'(ChDig0);
			if (c >= ChLowA && c <= ChLowF)
				return int'(c) - int'(ChLowA) + 10;
			if (c >= ChUpA && c <= ChUpF)
				return int'(c) - int'(ChUpA) + 10;
			return -1;
		endfunction

		// Appends one byte to the run of the current item.
		function void queue_byte(logic [7:0] c);
			run_bytes = {run_bytes, c};
		endfunction

		// A byte seen with no escape open.
		function void plain_char(logic [7:0] c);
			if (c == ChPercent) begin
				phase = PhPercent;
				held_digit = 8'h00;
			end else if (c == ChPlus) begin
				queue_byte(ChSpace);
			end else begin
				queue_byte(c);
			end
		endfunction

		// Notes an accepted item and queues the bytes it decodes to.
		function void note_item(logic [7:0] c, logic fin);
			decoded_t d;
			int       hi;
			int       lo;
			run_bytes.delete();
			lo = digit_value(c);
			case (phase)
				PhPercent: begin
					if (lo >= 0) begin
						held_digit = c;
						phase = PhDigit;
					end else begin
						queue_byte(ChPercent);
						phase = PhIdle;
						plain_char(c);
					end
				end
				PhDigit: begin
					if (lo >= 0) begin
						hi = digit_value(held_digit);
						queue_byte(8'((hi << 4) | lo));
						phase = PhIdle;
						held_digit = 8'h00;
					end else begin
						queue_byte(ChPercent);
						phase = PhIdle;
						plain_char(held_digit);
						held_digit = 8'h00;
						plain_char(c);
					end
				end
				default: begin
					phase = PhIdle;
					plain_char(c);
				end
			endcase
			// An escape still open at the end of the stream is flushed literally.
			if (fin) begin
				if (phase == PhPercent) begin
					queue_byte(ChPercent);
				end else if (phase == PhDigit) begin
					queue_byte(ChPercent);
					queue_byte(held_digit);
				end
				phase = PhIdle;
				held_digit = 8'h00;
			end
			foreach (run_bytes[k]) begin
				d.out_byte = run_bytes[k];
				d.run_end = (k == run_bytes.size() - 1);
				d.stream_end = d.run_end && fin;
				expected_bytes = {expected_bytes, d};
			end
		endfunction

		// Compares a popped byte with the oldest expected one, field by field.
		function void check_byte(logic [7:0] ob, logic re, logic se);
			decoded_t d;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %02h run_end %b stream_end %b",
					$time, ob, re, se);
				errors++;
				return;
			end
			d = expected_bytes.pop_front();
			if (ob !== d.out_byte) begin
				$display("%0t: out_byte expected %02h got %02h", $time, d.out_byte, ob);
				errors++;
			end
			if (re !== d.run_end) begin
				$display("%0t: run_end expected %b got %b", $time, d.run_end, re);
				errors++;
			end
			if (se !== d.stream_end) begin
				$display("%0t: stream_end expected %b got %b", $time, d.stream_end, se);
				errors++;
			end
		endfunction

		function int waiting();
			return expected_bytes.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;
	logic       stream_end;

	percent_board board = new();
	raw_item_t    token_q[$];
	int           burst_left = 0;
	int           items_sent = 0;
	int unsigned  cycle_count = 0;
	bit           hold_req = 1'b0;

	url_percent_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Accepted items feed the predictor; popped bytes are checked.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (push === 1'b1 && full === 1'b0)
				board.note_item(in_byte, final_byte);
			if (pop === 1'b1 && empty === 1'b0)
				board.check_byte(out_byte, run_end, stream_end);
		end
	end

	// Receiver: stretches of steady, random and periodic popping, plus long
	// hold-offs on request so that the block fills up.
	initial begin
		int mode;
		int stretch;
		int period;
		int tick;
		int stall_cnt;
		mode = 0;
		stretch = 0;
		period = 2;
		tick = 0;
		stall_cnt = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_cnt = HoldCycles;
				pop <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(10, 60);
					period = $urandom_range(2, 5);
				end
				stretch--;
				tick++;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ((tick % period) == 0);
					default: pop <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Offers one item and waits for the edge that takes it.
	task automatic send_item(logic [7:0] b, logic fin);
		push <= 1'b1;
		in_byte <= b;
		final_byte <= fin;
		do
			@(posedge clk);
		while (full !== 1'b0);
		items_sent++;
	endtask

	// Sends an item inside a burst; a new burst often opens with a random gap.
	task automatic offer(logic [7:0] b, logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		send_item(b, fin);
		burst_left--;
	endtask

	// Sender pause until every decoded byte has been popped. The task waits for a clock
	// edge before checking, so that the last accepted item has reached the predictor.
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	// Receiver holds off while plain bytes keep coming back to back.
	task automatic flood_while_held();
		hold_req = 1'b1;
		repeat (16)
			send_item(8'($urandom_range(97, 122)), 1'b0);
	endtask

	function automatic logic [7:0] pick_hex();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return ChDig0 + 8'(r);
		if (r < 16)
			return ChLowA + 8'(r - 10);
		return ChUpA + 8'(r - 16);
	endfunction

	// Non-hex character, often one just outside a digit or letter range.
	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0: c = 8'h2F;
			1: c = 8'h3A;
			2: c = 8'h40;
			3: c = 8'h47;
			4: c = 8'h60;
			5: c = 8'h67;
			6: c = ChPercent;
			7: c = ChPlus;
			default: begin
				do
					c = 8'($urandom_range(0, 255));
				while (percent_board::digit_value(c) >= 0);
			end
		endcase
		return c;
	endfunction

	function automatic raw_item_t mk(logic [7:0] b, logic fin);
		raw_item_t r;
		r.b = b;
		r.fin = fin;
		return r;
	endfunction

	// Appends one raw byte to the pending text.
	task automatic add_raw(logic [7:0] b, logic fin);
		token_q = {token_q, mk(b, fin)};
	endtask

	// Appends one random piece of encoded text, mostly well-formed escapes.
	task automatic add_token();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			add_raw(8'($urandom_range(0, 255)), 1'b0);
		end else if (kind < 50) begin
			add_raw(ChPlus, 1'b0);
		end else if (kind < 76) begin
			add_raw(ChPercent, 1'b0);
			add_raw(pick_hex(), 1'b0);
			add_raw(pick_hex(), 1'b0);
		end else if (kind < 84) begin
			add_raw(ChPercent, 1'b0);
			add_raw(pick_non_hex(), 1'b0);
		end else if (kind < 92) begin
			add_raw(ChPercent, 1'b0);
			add_raw(pick_hex(), 1'b0);
			add_raw(pick_non_hex(), 1'b0);
		end else if (kind < 96) begin
			add_raw(ChPercent, 1'b0);
			add_raw(pick_hex(), 1'b0);
		end else begin
			add_raw(ChPercent, 1'b0);
		end
		// End of stream, sometimes right inside an escape.
		if ($urandom_range(0, 9) == 0)
			token_q[token_q.size() - 1].fin = 1'b1;
	endtask

	// Main sequence.
	initial begin
		raw_item_t directed[$];
		raw_item_t it;
		bit        flood_a;
		bit        flood_b;
		flood_a = 1'b0;
		flood_b = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: byte extremes, plus, escapes of both cases, malformed
		// escapes, a percent after a percent, and streams ending inside escapes.
		directed = '{
			'{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{ChPlus, 1'b0},
			'{ChPercent, 1'b0}, '{8'h34, 1'b0}, '{8'h41, 1'b0},
			'{ChPercent, 1'b0}, '{8'h66, 1'b0}, '{8'h46, 1'b0},
			'{ChPercent, 1'b0}, '{ChPlus, 1'b0},
			'{ChPercent, 1'b0}, '{ChPercent, 1'b0}, '{8'h30, 1'b0}, '{8'h67, 1'b0},
			'{ChPercent, 1'b0}, '{8'h37, 1'b1},
			'{ChPercent, 1'b1},
			'{ChPercent, 1'b0}, '{8'h43, 1'b0}, '{8'h7A, 1'b1},
			'{ChPercent, 1'b0}, '{8'h39, 1'b0}, '{8'h61, 1'b1}
		};
		foreach (directed[i])
			offer(directed[i].b, directed[i].fin);
		drain_results();

		// Random text.
		items_sent = 0;
		while (items_sent < RandomItems) begin
			add_token();
			while (token_q.size() != 0) begin
				it = token_q.pop_front();
				offer(it.b, it.fin);
				if (it.fin && $urandom_range(0, 3) == 0)
					drain_results();
			end
			if (!flood_a && items_sent > 150) begin
				flood_a = 1'b1;
				flood_while_held();
			end
			if (!flood_b && items_sent > 320) begin
				flood_b = 1'b1;
				flood_while_held();
			end
		end
		push <= 1'b0;
		@(posedge clk);

		while (board.waiting() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (board.errors == 0 && board.waiting() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// ===== url_percent_decoder.f =====
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
test/tb_top.sv
